/* sv/kpd_pkg.sv */
// Package for the keypad scan, debounce and decode block.
// Holds payload and configuration types, register map and scan/decode functions.
// No dependencies.
package kpd_pkg;

    // Register map, word index into the configuration space
    localparam int unsigned RegAddrWidth = 4;
    localparam logic [1:0] REG_WINDOW_TICKS  = 2'd0;
    localparam logic [1:0] REG_MIN_MATCHES   = 2'd1;
    localparam logic [1:0] REG_HOLDOFF_TICKS = 2'd2;

    localparam logic [3:0]  WINDOW_TICKS_RST  = 4'd3;
    localparam logic [3:0]  MIN_MATCHES_RST   = 4'd2;
    localparam logic [15:0] HOLDOFF_TICKS_RST = 16'd100;

    // Column weights of the scan code
    localparam logic [2:0] COL0_WEIGHT = 3'b001;
    localparam logic [2:0] COL1_WEIGHT = 3'b010;
    localparam logic [2:0] COL2_WEIGHT = 3'b100;

    // Key table: scan codes
    localparam logic [6:0] CODE_STAR  = 7'h41;
    localparam logic [6:0] CODE_HASH  = 7'h11;
    localparam logic [6:0] CODE_KEY0  = 7'h21;
    localparam logic [6:0] CODE_KEY1  = 7'h48;
    localparam logic [6:0] CODE_KEY2  = 7'h28;
    localparam logic [6:0] CODE_KEY3  = 7'h18;
    localparam logic [6:0] CODE_KEY4  = 7'h44;
    localparam logic [6:0] CODE_KEY5  = 7'h24;
    localparam logic [6:0] CODE_KEY6  = 7'h14;
    localparam logic [6:0] CODE_KEY7  = 7'h42;
    localparam logic [6:0] CODE_KEY8  = 7'h22;
    localparam logic [6:0] CODE_KEY9  = 7'h12;

    localparam logic [7:0] CHAR_UNKNOWN = 8'h00;

    typedef struct packed {
        logic [3:0] rows_col0;
        logic [3:0] rows_col1;
        logic [3:0] rows_col2;
    } tick_t;

    typedef struct packed {
        logic [7:0] key_char;
        logic [6:0] key_code;
    } key_t;

    typedef struct packed {
        logic [3:0]  window_ticks;
        logic [3:0]  min_matches;
        logic [15:0] holdoff_ticks;
    } cfg_t;

    // Highest-numbered active column wins; zero when no row is high
    function automatic logic [6:0] scan_code(input tick_t t);
        logic [6:0] code;
        code = 7'd0;
        if (t.rows_col2 != 4'd0)
        begin
            code = {COL2_WEIGHT, t.rows_col2};
        end
        else if (t.rows_col1 != 4'd0)
        begin
            code = {COL1_WEIGHT, t.rows_col1};
        end
        else if (t.rows_col0 != 4'd0)
        begin
            code = {COL0_WEIGHT, t.rows_col0};
        end
        return code;
    endfunction

    function automatic logic [7:0] decode_key(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            CODE_STAR: ch = "*";
            CODE_HASH: ch = "#";
            CODE_KEY0: ch = "0";
            CODE_KEY1: ch = "1";
            CODE_KEY2: ch = "2";
            CODE_KEY3: ch = "3";
            CODE_KEY4: ch = "4";
            CODE_KEY5: ch = "5";
            CODE_KEY6: ch = "6";
            CODE_KEY7: ch = "7";
            CODE_KEY8: ch = "8";
            CODE_KEY9: ch = "9";
            default:   ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

/* sv/kpd_apb_regs.sv */
// Configuration registers of the keypad block behind an APB-style port.
// Depends on kpd_pkg for the register map and cfg_t.
module kpd_apb_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kpd_pkg::RegAddrWidth-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output kpd_pkg::cfg_t                    cfg
);

    kpd_pkg::cfg_t cfg_reg;
    kpd_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                kpd_pkg::REG_WINDOW_TICKS:  cfg_next.window_ticks  = pwdata[3:0];
                kpd_pkg::REG_MIN_MATCHES:   cfg_next.min_matches   = pwdata[3:0];
                kpd_pkg::REG_HOLDOFF_TICKS: cfg_next.holdoff_ticks = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ticks  <= kpd_pkg::WINDOW_TICKS_RST;
            cfg_reg.min_matches   <= kpd_pkg::MIN_MATCHES_RST;
            cfg_reg.holdoff_ticks <= kpd_pkg::HOLDOFF_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            kpd_pkg::REG_WINDOW_TICKS:  prdata = {28'd0, cfg_reg.window_ticks};
            kpd_pkg::REG_MIN_MATCHES:   prdata = {28'd0, cfg_reg.min_matches};
            kpd_pkg::REG_HOLDOFF_TICKS: prdata = {16'd0, cfg_reg.holdoff_ticks};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* sv/kpd_scan_stage.sv */
// Input register stage: takes a tick transfer and holds its scan code.
// Depends on kpd_pkg for tick_t and scan_code().
module kpd_scan_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick_valid,
    output logic           tick_stall,
    input  kpd_pkg::tick_t tick,
    input  logic           advance,
    output logic           code_valid,
    output logic [6:0]     code
);

    logic       valid_reg;
    logic       valid_next;
    logic [6:0] code_reg;
    logic       load;

    // Hold the stage while its item cannot move on
    assign tick_stall = valid_reg && !advance;
    assign load       = tick_valid && !tick_stall;
    assign valid_next = tick_stall ? valid_reg : tick_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= kpd_pkg::scan_code(tick);
        end
    end

    assign code_valid = valid_reg;
    assign code       = code_reg;

endmodule

/* sv/kpd_debounce.sv */
// Debounce window, holdoff counter and result register of the keypad block.
// Depends on kpd_pkg for cfg_t, key_t and decode_key().
module kpd_debounce
(
    input  logic          clk,
    input  logic          rst_n,
    input  kpd_pkg::cfg_t cfg,
    input  logic          code_valid,
    input  logic [6:0]    code,
    output logic          advance,
    output logic          key_valid,
    input  logic          key_stall,
    output kpd_pkg::key_t key
);

    logic [6:0]    saved_code_reg;
    logic [6:0]    saved_code_next;
    logic [3:0]    window_pos_reg;
    logic [3:0]    window_pos_next;
    logic [3:0]    match_count_reg;
    logic [3:0]    match_count_next;
    logic [15:0]   holdoff_left_reg;
    logic [15:0]   holdoff_left_next;
    logic          key_valid_reg;
    logic          key_valid_next;
    kpd_pkg::key_t key_reg;

    logic          step;
    logic          opening;
    logic          in_window;
    logic [3:0]    count_base;
    logic [3:0]    count_inc;
    logic [3:0]    pos_inc;
    logic [3:0]    win_len;
    logic          closing;
    logic          emit;

    // The result register frees up when empty or being taken
    assign advance = !key_valid_reg || !key_stall;
    assign step    = code_valid && advance;

    always_comb
    begin
        saved_code_next   = saved_code_reg;
        window_pos_next   = window_pos_reg;
        match_count_next  = match_count_reg;
        holdoff_left_next = holdoff_left_reg;
        emit              = 1'b0;

        opening    = (window_pos_reg == 4'd0) && (code != 7'd0);
        in_window  = (window_pos_reg != 4'd0) || opening;
        count_base = opening ? 4'd0 : match_count_reg;
        count_inc  = (code == (opening ? code : saved_code_reg)) ? count_base + 4'd1
                                                                  : count_base;
        pos_inc    = window_pos_reg + 4'd1;
        win_len    = (cfg.window_ticks == 4'd0) ? 4'd1 : cfg.window_ticks;
        closing    = (pos_inc >= win_len) || (pos_inc == 4'd0);

        if (step)
        begin
            if (holdoff_left_reg != 16'd0)
            begin
                holdoff_left_next = holdoff_left_reg - 16'd1;
            end
            else if (in_window)
            begin
                if (opening)
                begin
                    saved_code_next = code;
                end
                match_count_next = count_inc;
                if (closing)
                begin
                    window_pos_next = 4'd0;
                    if (count_inc >= cfg.min_matches)
                    begin
                        emit              = 1'b1;
                        holdoff_left_next = cfg.holdoff_ticks;
                    end
                end
                else
                begin
                    window_pos_next = pos_inc;
                end
            end
        end
    end

    always_comb
    begin
        key_valid_next = key_valid_reg;
        if (key_valid_reg && !key_stall)
        begin
            key_valid_next = 1'b0;
        end
        if (step)
        begin
            key_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_code_reg   <= 7'd0;
            window_pos_reg   <= 4'd0;
            match_count_reg  <= 4'd0;
            holdoff_left_reg <= 16'd0;
            key_valid_reg    <= 1'b0;
        end
        else
        begin
            saved_code_reg   <= saved_code_next;
            window_pos_reg   <= window_pos_next;
            match_count_reg  <= match_count_next;
            holdoff_left_reg <= holdoff_left_next;
            key_valid_reg    <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            key_reg.key_char <= kpd_pkg::decode_key(saved_code_next);
            key_reg.key_code <= saved_code_next;
        end
    end

    assign key_valid = key_valid_reg;
    assign key       = key_reg;

    // A holdoff only starts when a window closes
    a_holdoff_window_closed: assert property (@(posedge clk) disable iff (!rst_n)
        holdoff_left_reg != 16'd0 |-> window_pos_reg == 4'd0)
        else $error("holdoff running with window open");

    // An open window always has a nonzero code with a single column weight
    a_open_saved_code: assert property (@(posedge clk) disable iff (!rst_n)
        window_pos_reg != 4'd0 |-> saved_code_reg != 7'd0 && $onehot(saved_code_reg[6:4]))
        else $error("open window without a valid saved code");

    // At most one match per tick in the window
    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        window_pos_reg != 4'd0 |-> match_count_reg <= window_pos_reg)
        else $error("match count exceeds window position");

endmodule

/* sv/keypad_scan_debounce_decode.sv */
// Top level of the 3x4 keypad scanner with debounce and key decode.
// Depends on kpd_pkg, kpd_apb_regs, kpd_scan_stage and kpd_debounce.
//
//  port group  | direction | handshake             | payload
//  ------------+-----------+-----------------------+---------------------------------
//  tick        | in        | tick_valid/tick_stall | rows_col0, rows_col1, rows_col2
//  key         | out       | key_valid/key_stall   | key_char, key_code
//  apb         | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
// One tick transfer is taken per cycle while tick_stall is low; key_valid rises
// once the transfer closing its window has passed the input and then the result register.
// Reset (rst_n low) closes the window, clears holdoff and loads register defaults.
// key_stall holds the result register; tick_stall rises only while a full input
// register waits behind a held result.
module keypad_scan_debounce_decode
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Tick channel: one row sample per column
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  kpd_pkg::tick_t                   tick,
    // Key channel: accepted key
    output logic                             key_valid,
    input  logic                             key_stall,
    output kpd_pkg::key_t                    key,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kpd_pkg::RegAddrWidth-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    kpd_pkg::cfg_t cfg;
    logic          code_valid;
    logic [6:0]    code;
    logic          advance;

    // Window length, match threshold and holdoff length
    kpd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Register each tick transfer as its scan code
    kpd_scan_stage u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .advance    (advance),
        .code_valid (code_valid),
        .code       (code)
    );

    // Advance the window and holdoff, register the decoded key
    kpd_debounce u_debounce
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .code_valid (code_valid),
        .code       (code),
        .advance    (advance),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key        (key)
    );

endmodule
